@@ rtl/irm_pkg.sv @@
// Package for the interval room assigner: sizes, heap entry type, controller states,
// and the command/status structs shared by controller and datapath. No dependencies.
`default_nettype none

package irm_pkg;

	localparam int MAX_ROOMS = 64;
	localparam int HEAP_AW   = $clog2(MAX_ROOMS);
	localparam int CNT_W     = $clog2(MAX_ROOMS + 1);
	localparam int IDX_W     = HEAP_AW + 2;
	localparam int TIME_W    = 31;
	localparam int ID_W      = 16;
	localparam int ROOM_W    = 7;

	typedef struct packed {
		logic [TIME_W-1:0] free_time;
		logic [CNT_W-1:0]  room;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_DN_RD,
		S_DN_CMP,
		S_UP_RD,
		S_UP_CMP,
		S_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic decide;
		logic dn_rd;
		logic dn_cmp;
		logic up_rd;
		logic up_cmp;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic reuse;
		logic can_open;
		logic dn_stop;
		logic up_root;
		logic up_stop;
	} status_t;

	// Heap order: earlier free time first, lower room number on a tie.
	function automatic logic entry_before(entry_t a, entry_t b);
		logic r;
		if (a.free_time != b.free_time) begin
			r = a.free_time < b.free_time;
		end else begin
			r = a.room < b.room;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/irm_if.sv @@
// Channel interfaces for the interval room assigner: input interval beat and result beat.
// Depends on irm_pkg for field widths.
`default_nettype none

interface irm_in_if;
	logic                        valid;
	logic                        ready;
	logic [irm_pkg::TIME_W-1:0]  start_time;
	logic [irm_pkg::TIME_W-1:0]  end_time;
	logic [irm_pkg::ID_W-1:0]    item_id;
	logic                        first_of_set;

	modport source (output valid, start_time, end_time, item_id, first_of_set, input ready);
	modport sink   (input valid, start_time, end_time, item_id, first_of_set, output ready);
endinterface

interface irm_out_if;
	logic                        valid;
	logic                        ready;
	logic [irm_pkg::ID_W-1:0]    item_tag;
	logic [irm_pkg::ROOM_W-1:0]  room;
	logic [irm_pkg::ROOM_W-1:0]  rooms_opened;
	logic                        overflow;

	modport source (output valid, item_tag, room, rooms_opened, overflow, input ready);
	modport sink   (input valid, item_tag, room, rooms_opened, overflow, output ready);
endinterface

`default_nettype wire

@@ rtl/irm_ctrl.sv @@
// Controller for the interval room assigner: sequences accept, decision, heap sift steps
// and result hand-off. Depends on irm_pkg.
`default_nettype none

module irm_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire irm_pkg::status_t  status,
	output irm_pkg::cmd_t          cmd
);
	import irm_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (status.reuse) begin
					state_d = S_DN_RD;
				end else if (status.can_open) begin
					state_d = S_UP_RD;
				end else begin
					state_d = S_FIN;
				end
			end
			S_DN_RD:  state_d = S_DN_CMP;
			S_DN_CMP: state_d = status.dn_stop ? S_FIN : S_DN_RD;
			S_UP_RD:  state_d = status.up_root ? S_FIN : S_UP_CMP;
			S_UP_CMP: state_d = status.up_stop ? S_FIN : S_UP_RD;
			S_FIN: begin
				if (out_free) state_d = S_IDLE;
			end
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:   cmd.load   = in_valid;
			S_DECIDE: cmd.decide = 1'b1;
			S_DN_RD:  cmd.dn_rd  = 1'b1;
			S_DN_CMP: cmd.dn_cmp = 1'b1;
			S_UP_RD:  cmd.up_rd  = 1'b1;
			S_UP_CMP: cmd.up_cmp = 1'b1;
			S_FIN:    cmd.fin    = out_free;
			default:  cmd        = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_cmd_onehot0: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("controller issued more than one command");
	a_load_goes_decide: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_DECIDE))
		else $error("accepted beat not followed by decision");
	a_fin_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> out_valid_q)
		else $error("result not presented after finish");
`endif

endmodule

`default_nettype wire

@@ rtl/irm_dpath.sv @@
// Datapath for the interval room assigner: heap memory with two registered read ports,
// hole register for the moving entry, counters and result register. Depends on irm_pkg.
`default_nettype none

module irm_dpath (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [irm_pkg::TIME_W-1:0] start_time,
	input  wire logic [irm_pkg::TIME_W-1:0] end_time,
	input  wire logic [irm_pkg::ID_W-1:0]   item_id,
	input  wire logic                       first_of_set,
	input  wire irm_pkg::cmd_t              cmd,
	output irm_pkg::status_t                status,
	output logic [irm_pkg::ID_W-1:0]        item_tag,
	output logic [irm_pkg::ROOM_W-1:0]      room,
	output logic [irm_pkg::ROOM_W-1:0]      rooms_opened,
	output logic                            overflow
);
	import irm_pkg::*;

	entry_t mem_q [MAX_ROOMS];
	entry_t rd_a_q, rd_b_q;

	logic [TIME_W-1:0] start_q, end_q;
	logic [ID_W-1:0]   tag_q;
	logic [CNT_W-1:0]  count_q, total_q;
	entry_t            x_q;
	logic [HEAP_AW-1:0] idx_q;
	logic [CNT_W-1:0]  res_room_q;
	logic              res_ovf_q;

	logic [IDX_W-1:0]   idx_w, cnt_w, l_idx, r_idx, p_idx;
	logic               l_ok, r_ok, l_win, r_win;
	entry_t             best;
	logic [HEAP_AW-1:0] rd_a_addr, rd_b_addr, wr_addr;
	entry_t             wr_data;
	logic               wr_en;
	logic [CNT_W-1:0]   total_inc;

	assign idx_w = IDX_W'(idx_q);
	assign cnt_w = IDX_W'(count_q);
	assign l_idx = (idx_w << 1) + IDX_W'(1);
	assign r_idx = (idx_w << 1) + IDX_W'(2);
	assign p_idx = (idx_w - IDX_W'(1)) >> 1;
	assign l_ok  = l_idx < cnt_w;
	assign r_ok  = r_idx < cnt_w;
	assign total_inc = total_q + CNT_W'(1);

	// Pick the smallest of hole entry, left child and right child.
	always_comb begin
		best  = x_q;
		l_win = 1'b0;
		r_win = 1'b0;
		if (l_ok && entry_before(rd_a_q, x_q)) begin
			best  = rd_a_q;
			l_win = 1'b1;
		end
		if (r_ok && entry_before(rd_b_q, best)) begin
			best  = rd_b_q;
			r_win = 1'b1;
			l_win = 1'b0;
		end
	end

	always_comb begin
		status.reuse    = (count_q != '0) && (rd_a_q.free_time <= start_q);
		status.can_open = count_q < CNT_W'(MAX_ROOMS);
		status.dn_stop  = !l_win && !r_win;
		status.up_root  = (idx_q == '0);
		status.up_stop  = !entry_before(x_q, rd_a_q);
	end

	// Read ports: root while idle, children while sifting down, parent while sifting up.
	always_comb begin
		rd_a_addr = '0;
		if (cmd.dn_rd) begin
			rd_a_addr = l_idx[HEAP_AW-1:0];
		end else if (cmd.up_rd) begin
			rd_a_addr = p_idx[HEAP_AW-1:0];
		end
		rd_b_addr = r_idx[HEAP_AW-1:0];
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = x_q;
		if (cmd.dn_cmp) begin
			wr_en   = 1'b1;
			wr_data = best;
		end else if (cmd.up_rd && status.up_root) begin
			wr_en   = 1'b1;
		end else if (cmd.up_cmp) begin
			wr_en   = 1'b1;
			wr_data = status.up_stop ? x_q : rd_a_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		rd_a_q <= mem_q[rd_a_addr];
		rd_b_q <= mem_q[rd_b_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			total_q <= '0;
		end else if (cmd.load && first_of_set) begin
			count_q <= '0;
			total_q <= '0;
		end else if (cmd.decide && !status.reuse && status.can_open) begin
			count_q <= count_q + CNT_W'(1);
			total_q <= total_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			start_q <= start_time;
			end_q   <= end_time;
			tag_q   <= item_id;
		end
		if (cmd.decide) begin
			x_q.free_time <= end_q;
			if (status.reuse) begin
				x_q.room   <= rd_a_q.room;
				idx_q      <= '0;
				res_room_q <= rd_a_q.room;
				res_ovf_q  <= 1'b0;
			end else if (status.can_open) begin
				x_q.room   <= total_inc;
				idx_q      <= count_q[HEAP_AW-1:0];
				res_room_q <= total_inc;
				res_ovf_q  <= 1'b0;
			end else begin
				x_q.room   <= '0;
				res_room_q <= '0;
				res_ovf_q  <= 1'b1;
			end
		end
		// Advance the hole to the winning child or to the parent.
		if (cmd.dn_cmp && !status.dn_stop) begin
			idx_q <= r_win ? r_idx[HEAP_AW-1:0] : l_idx[HEAP_AW-1:0];
		end
		if (cmd.up_cmp && !status.up_stop) begin
			idx_q <= p_idx[HEAP_AW-1:0];
		end
		if (cmd.fin) begin
			item_tag     <= tag_q;
			room         <= ROOM_W'(res_room_q);
			rooms_opened <= ROOM_W'(total_q);
			overflow     <= res_ovf_q;
		end
	end

`ifndef ASSERT_OFF
	a_count_total: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == total_q)
		else $error("heap count and room total diverged");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ROOMS))
		else $error("heap count above capacity");
	a_dn_hole: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dn_cmp |-> (idx_w < cnt_w))
		else $error("sift-down hole outside heap");
	a_up_hole: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.up_rd |-> (idx_w < cnt_w))
		else $error("sift-up hole outside heap");
`endif

endmodule

`default_nettype wire

@@ rtl/interval_room_assigner.sv @@
// Interval room assigner: greedy room reuse over a min-heap of free times (64 rooms).
// Per item: a decision, then a heap sift down (reuse) or up (new room) with a read and a
// compare-write step per level, or straight to finish on overflow; the finish state stalls
// until the result register is free. Items are taken one at a time, only while idle.
// The next item is taken while a result waits.
// Reset: arst_n clears heap count, room total, state and result valid, not the heap memory.
`default_nettype none

module interval_room_assigner (
	input  wire logic clk,
	input  wire logic arst_n,
	irm_in_if.sink    item,
	irm_out_if.source result
);
	import irm_pkg::*;

	cmd_t    cmd;
	status_t status;

	irm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	irm_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.start_time   (item.start_time),
		.end_time     (item.end_time),
		.item_id      (item.item_id),
		.first_of_set (item.first_of_set),
		.cmd          (cmd),
		.status       (status),
		.item_tag     (result.item_tag),
		.room         (result.room),
		.rooms_opened (result.rooms_opened),
		.overflow     (result.overflow)
	);

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Testbench top for interval_room_assigner: sends interval beats, predicts each room
// assignment with a local min-heap of rooms and checks every result beat in order.
// Depends on irm_pkg, the irm_in_if/irm_out_if interfaces and the RTL top module.

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import irm_pkg::*;

	localparam logic [TIME_W-1:0] T_MAX = '1;

	typedef struct packed {
		logic [TIME_W-1:0] start_time;
		logic [TIME_W-1:0] end_time;
		logic [ID_W-1:0]   item_id;
		logic              first_of_set;
	} interval_t;

	typedef struct packed {
		logic [ID_W-1:0]   item_tag;
		logic [ROOM_W-1:0] room;
		logic [ROOM_W-1:0] rooms_opened;
		logic              overflow;
	} assignment_t;

	logic clk;
	logic arst_n;

	irm_in_if  item_ch();
	irm_out_if result_ch();

	interval_room_assigner uut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch)
	);

	// Predicted heap of rooms, keyed by free time, then room number.
	logic [TIME_W-1:0] slot_free [MAX_ROOMS];
	int                slot_room [MAX_ROOMS];
	int                live_slots;
	int                rooms_tally;

	assignment_t pending_assignments[$];
	int          fail_count;
	bit          in_idle_on;
	bit          out_idle_on;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic int idle_len(bit enabled);
		int r;
		if (!enabled) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic bit slot_before(int a, int b);
		if (slot_free[a] != slot_free[b]) return slot_free[a] < slot_free[b];
		return slot_room[a] < slot_room[b];
	endfunction

	function automatic void swap_slots(int a, int b);
		logic [TIME_W-1:0] f;
		int                r;
		f = slot_free[a];
		r = slot_room[a];
		slot_free[a] = slot_free[b];
		slot_room[a] = slot_room[b];
		slot_free[b] = f;
		slot_room[b] = r;
	endfunction

	function automatic assignment_t assign_room(interval_t iv);
		assignment_t res;
		int          i;
		int          l;
		int          m;
		bit          settled;
		res.item_tag = iv.item_id;
		res.room = '0;
		res.overflow = 1'b0;
		if (iv.first_of_set) begin
			live_slots = 0;
			rooms_tally = 0;
		end
		if (live_slots > 0 && slot_free[0] <= iv.start_time) begin
			// Reuse the earliest free room, then sift it down.
			res.room = ROOM_W'(slot_room[0]);
			slot_free[0] = iv.end_time;
			i = 0;
			settled = 1'b0;
			while (!settled) begin
				m = i;
				l = 2 * i + 1;
				if (l < live_slots && slot_before(l, m)) m = l;
				if (l + 1 < live_slots && slot_before(l + 1, m)) m = l + 1;
				if (m == i) begin
					settled = 1'b1;
				end else begin
					swap_slots(i, m);
					i = m;
				end
			end
		end else if (live_slots < MAX_ROOMS) begin
			rooms_tally++;
			res.room = ROOM_W'(rooms_tally);
			slot_free[live_slots] = iv.end_time;
			slot_room[live_slots] = rooms_tally;
			i = live_slots;
			live_slots++;
			while (i > 0 && slot_before(i, (i - 1) / 2)) begin
				swap_slots(i, (i - 1) / 2);
				i = (i - 1) / 2;
			end
		end else begin
			res.overflow = 1'b1;
		end
		res.rooms_opened = ROOM_W'(rooms_tally);
		return res;
	endfunction

	function automatic interval_t iv_of(logic [TIME_W-1:0] s, logic [TIME_W-1:0] e,
			logic [ID_W-1:0] id, logic first);
		interval_t iv;
		iv.start_time = s;
		iv.end_time = e;
		iv.item_id = id;
		iv.first_of_set = first;
		return iv;
	endfunction

	// Call right after a rising edge; returns at the edge that takes the beat.
	task automatic send_interval(interval_t iv);
		int gap;
		gap = idle_len(in_idle_on);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.start_time <= iv.start_time;
		item_ch.end_time <= iv.end_time;
		item_ch.item_id <= iv.item_id;
		item_ch.first_of_set <= iv.first_of_set;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		pending_assignments = {pending_assignments, assign_room(iv)};
	endtask

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		assignment_t want;
		if (arst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (pending_assignments.size() == 0) begin
				$error("result beat with no interval pending: item_tag %0h", result_ch.item_tag);
				fail_count++;
			end else begin
				want = pending_assignments.pop_front();
				check_field("item_tag", int'(want.item_tag), int'(result_ch.item_tag));
				check_field("room", int'(want.room), int'(result_ch.room));
				check_field("rooms_opened", int'(want.rooms_opened),
					int'(result_ch.rooms_opened));
				check_field("overflow", int'(want.overflow), int'(result_ch.overflow));
			end
		end
	end

	// Result-side backpressure: runs of ready with stalls of random length.
	initial begin : result_stalls
		int hold;
		int stall;
		bit rdy;
		hold = 0;
		rdy = 1'b0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
			end else begin
				stall = rdy ? idle_len(out_idle_on) : 0;
				rdy = (stall == 0);
				hold = rdy ? $urandom_range(0, 6) : stall - 1;
				result_ch.ready <= rdy;
			end
		end
	end

	task automatic test_open_and_reuse();
		send_interval(iv_of(0, 10, 16'h0000, 1'b1));
		send_interval(iv_of(0, 5, 16'h1234, 1'b0));
		// Room free exactly at the start is reused.
		send_interval(iv_of(5, T_MAX, 16'h00ff, 1'b0));
		send_interval(iv_of(9, 20, 16'h0100, 1'b0));
		send_interval(iv_of(10, 10, 16'h5555, 1'b0));
		send_interval(iv_of(10, 11, 16'haaaa, 1'b0));
	endtask

	task automatic test_equal_free_times();
		send_interval(iv_of(0, 7, 16'h0001, 1'b1));
		send_interval(iv_of(0, 7, 16'h0002, 1'b0));
		send_interval(iv_of(0, 7, 16'h0003, 1'b0));
		// Lowest room number wins among equally early rooms.
		send_interval(iv_of(7, 8, 16'h0004, 1'b0));
		send_interval(iv_of(7, 9, 16'h0005, 1'b0));
		send_interval(iv_of(8, 30, 16'h0006, 1'b0));
	endtask

	task automatic test_odd_intervals();
		// End before start, then a start earlier than the one before.
		send_interval(iv_of(100, 3, 16'h0010, 1'b1));
		send_interval(iv_of(2, 50, 16'h0011, 1'b0));
		send_interval(iv_of(3, 0, 16'h0012, 1'b0));
		send_interval(iv_of(T_MAX, T_MAX, 16'hffff, 1'b0));
		send_interval(iv_of(T_MAX, 0, 16'h8000, 1'b0));
		send_interval(iv_of(T_MAX, T_MAX, 16'h7fff, 1'b1));
		send_interval(iv_of(0, 0, 16'h0000, 1'b0));
	endtask

	task automatic test_heap_full();
		int k;
		for (k = 0; k < MAX_ROOMS; k++)
			send_interval(iv_of(0, TIME_W'(1000 + k), ID_W'(k), k == 0));
		repeat (3) send_interval(iv_of(5, 6, 16'hdead, 1'b0));
		send_interval(iv_of(1000, 2000, 16'hbeef, 1'b0));
		send_interval(iv_of(1000, 2000, 16'hcafe, 1'b0));
		// A new set clears the heap after overflow.
		send_interval(iv_of(0, 1, 16'h0042, 1'b1));
	endtask

	task automatic test_random_sets();
		int                sent;
		int                set_len;
		int                step_max;
		int                dur_max;
		int                kind;
		int                k;
		logic [TIME_W-1:0] t;
		interval_t         iv;
		sent = 0;
		while (sent < 940) begin
			kind = $urandom_range(0, 99);
			if (kind < 10) begin
				// Crowded set: overlaps pile up past the heap size.
				set_len = $urandom_range(66, 90);
				step_max = 2;
				dur_max = 1 << 24;
			end else if (kind < 25) begin
				set_len = $urandom_range(41, 70);
				step_max = $urandom_range(0, 20);
				dur_max = $urandom_range(100, 5000);
			end else begin
				set_len = $urandom_range(1, 40);
				step_max = $urandom_range(0, 50);
				dur_max = $urandom_range(0, 400);
			end
			case ($urandom_range(0, 4))
				0, 1: t = TIME_W'($urandom_range(0, 1000));
				2, 3: t = TIME_W'($urandom);
				default: t = TIME_W'(T_MAX - $urandom_range(0, 4000));
			endcase
			case ($urandom_range(0, 9))
				0, 1: begin
					in_idle_on = 1'b0;
					out_idle_on = 1'b0;
				end
				2: begin
					in_idle_on = 1'b1;
					out_idle_on = 1'b0;
				end
				default: begin
					in_idle_on = 1'b1;
					out_idle_on = 1'b1;
				end
			endcase
			for (k = 0; k < set_len; k++) begin
				// Most sets open with the flag; the rest continue the previous one.
				iv.first_of_set = (k == 0) && ($urandom_range(0, 9) != 0);
				iv.item_id = ID_W'($urandom);
				if ($urandom_range(0, 24) == 0) begin
					iv.start_time = TIME_W'($urandom);
				end else begin
					t = TIME_W'(t + $urandom_range(0, step_max));
					iv.start_time = t;
				end
				if ($urandom_range(0, 29) == 0)
					iv.end_time = TIME_W'($urandom);
				else
					iv.end_time = TIME_W'(iv.start_time + $urandom_range(0, dur_max));
				send_interval(iv);
			end
			sent += set_len;
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.start_time <= '0;
		item_ch.end_time <= '0;
		item_ch.item_id <= '0;
		item_ch.first_of_set <= 1'b0;
		fail_count = 0;
		live_slots = 0;
		rooms_tally = 0;
		in_idle_on = 1'b1;
		out_idle_on = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_open_and_reuse();
		test_equal_free_times();
		test_odd_intervals();
		test_heap_full();
		test_random_sets();
		item_ch.valid <= 1'b0;
		while (pending_assignments.size() != 0) @(posedge clk);
		repeat (32) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
